FILE: rtl/pan_pkg.sv
package pan_pkg;

	localparam int COORD_W = 16;
	localparam int SUM_W   = 42;
	localparam int AREA_W  = 41;
	localparam int MUL_W   = 22;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int HALF_W  = SUM_W / 2;
	localparam int ROOT_W  = 44;
	localparam int SQ_W    = 2 * ROOT_W;
	localparam int REM_W   = ROOT_W + 4;
	localparam int STEP_W  = 6;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [1:0] PART_LL = 2'd0;
	localparam logic [1:0] PART_HL = 2'd1;
	localparam logic [1:0] PART_HH = 2'd2;

	localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(12);
	localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_SAT,
		RES_ROOT
	} res_sel_t;

	typedef struct packed {
		logic       take;
		logic       edge_mul;
		logic       edge_acc;
		logic [1:0] axis;
		logic [1:0] axis_acc;
		logic       close;
		logic       sq_clr;
		logic       sq_mag;
		logic       sq_mul;
		logic       sq_acc;
		logic [1:0] part;
		logic       root_step;
		logic       load_res;
		res_sel_t   res_sel;
	} cmd_t;

	typedef struct packed {
		logic has_prev;
		logic in_last;
		logic ovf;
		logic few;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/pan_vertex_if.sv
interface pan_vertex_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_coord;
	logic signed [15:0] y_coord;
	logic signed [15:0] z_coord;
	logic               last_vertex;

	modport source (output valid, output x_coord, output y_coord, output z_coord,
		output last_vertex, input ready);
	modport sink (input valid, input x_coord, input y_coord, input z_coord,
		input last_vertex, output ready);
endinterface

FILE: rtl/pan_result_if.sv
interface pan_result_if;
	logic        valid;
	logic        ready;
	logic [40:0] area;
	logic        vertex_overflow;

	modport source (output valid, output area, output vertex_overflow, input ready);
	modport sink (input valid, input area, input vertex_overflow, output ready);
endinterface

FILE: rtl/polygon_area_newell.sv
// vertices: one with a predecessor sends x, y, z edge terms through one shared multiplier
//   (states M0, M1, M2, ACC); one that opens a polygon or is past the limit skips them
// closing: under three vertices loads zero, overflow saturates, else the closing edge,
//   squares, 44-bit root at one bit a cycle; loads wait until the prior result is taken
// reset: arst_n clears the controller, vertex count, sums and output valid at once
module polygon_area_newell #(
	parameter int MAX_VERTS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	pan_vertex_if.sink      vtx,
	pan_result_if.source    res
);
	import pan_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller: sequences edge terms, closing edge, squares, root steps and the result load
	pan_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vtx.valid),
		.in_ready (vtx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: vertex registers, newell sums, shared multiplier, square root,
	// and the result register that lets new vertices in while a result waits
	pan_dp #(
		.MAX_VERTS (MAX_VERTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.x_coord         (vtx.x_coord),
		.y_coord         (vtx.y_coord),
		.z_coord         (vtx.z_coord),
		.last_vertex     (vtx.last_vertex),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (res.valid),
		.out_ready       (res.ready),
		.area            (res.area),
		.vertex_overflow (res.vertex_overflow)
	);

`ifndef ASSERT_OFF
	// a result is never written over one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> sts.out_free)
		else $error("result register overwritten");

	// result valid appears only after a result load
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(cmd.load_res))
		else $error("result valid without load");

	// no vertex request is taken while the back end squares or takes the root
	a_no_take_in_back_end: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx.valid && vtx.ready) |-> !(cmd.sq_mul || cmd.sq_acc || cmd.root_step))
		else $error("vertex taken during back end");
`endif
endmodule

FILE: rtl/pan_ctrl.sv
module pan_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pan_pkg::sts_t  sts,
	output pan_pkg::cmd_t  cmd
);
	import pan_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_M0,
		S_M1,
		S_M2,
		S_ACC,
		S_END,
		S_SQ,
		S_ROOT,
		S_RES
	} state_t;

	state_t              state_q;
	logic                closing_q;
	logic                last_q;
	logic [STEP_W-1:0]   step_q;
	res_sel_t            sel_q;
	logic [1:0]          phase;
	logic                take;

	assign phase    = step_q[1:0];
	assign in_ready = (state_q == S_IDLE) || (state_q == S_ACC && !closing_q && !last_q);
	assign take     = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		cmd.res_sel  = sel_q;
		cmd.take     = take;
		case (state_q)
			S_M0: begin
				cmd.edge_mul = 1'b1;
				cmd.axis     = AXIS_X;
			end
			S_M1: begin
				cmd.edge_mul = 1'b1;
				cmd.axis     = AXIS_Y;
				cmd.edge_acc = 1'b1;
				cmd.axis_acc = AXIS_X;
			end
			S_M2: begin
				cmd.edge_mul = 1'b1;
				cmd.axis     = AXIS_Z;
				cmd.edge_acc = 1'b1;
				cmd.axis_acc = AXIS_Y;
			end
			S_ACC: begin
				cmd.edge_acc = 1'b1;
				cmd.axis_acc = AXIS_Z;
				cmd.sq_clr   = closing_q;
			end
			S_END: begin
				cmd.close = !sts.ovf && !sts.few;
			end
			S_SQ: begin
				cmd.axis   = step_q[3:2];
				cmd.sq_mag = (phase == 2'd0) && (step_q != SQ_LAST);
				cmd.sq_mul = (phase != 2'd0);
				cmd.part   = phase - 2'd1;
				cmd.sq_acc = ((phase == 2'd0) && (step_q != '0)) || (phase[1] == 1'b1);
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
			end
			S_RES: begin
				cmd.load_res = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			closing_q <= 1'b0;
			last_q    <= 1'b0;
			step_q    <= '0;
			sel_q     <= RES_ZERO;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						last_q  <= sts.in_last;
						state_q <= sts.has_prev ? S_M0 : (sts.in_last ? S_END : S_IDLE);
					end
				end
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_ACC;
				S_ACC: begin
					if (take) begin
						last_q  <= sts.in_last;
						state_q <= sts.has_prev ? S_M0 : (sts.in_last ? S_END : S_IDLE);
					end else if (closing_q) begin
						step_q  <= '0;
						state_q <= S_SQ;
					end else if (last_q) begin
						state_q <= S_END;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_END: begin
					if (sts.ovf) begin
						sel_q   <= RES_SAT;
						state_q <= S_RES;
					end else if (sts.few) begin
						sel_q   <= RES_ZERO;
						state_q <= S_RES;
					end else begin
						closing_q <= 1'b1;
						state_q   <= S_M0;
					end
				end
				S_SQ: begin
					if (step_q == SQ_LAST) begin
						step_q  <= '0;
						state_q <= S_ROOT;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_ROOT: begin
					if (step_q == ROOT_LAST) begin
						sel_q   <= RES_ROOT;
						state_q <= S_RES;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_RES: begin
					if (sts.out_free) begin
						closing_q <= 1'b0;
						last_q    <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/pan_dp.sv
module pan_dp #(
	parameter int MAX_VERTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	input  logic signed [15:0] z_coord,
	input  logic               last_vertex,
	input  pan_pkg::cmd_t      cmd,
	output pan_pkg::sts_t      sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [40:0]        area,
	output logic               vertex_overflow
);
	import pan_pkg::*;

	localparam int CNT_W = $clog2(MAX_VERTS + 1);

	logic signed [COORD_W-1:0] in_v [3];
	logic signed [COORD_W-1:0] first_q [3];
	logic signed [COORD_W-1:0] prev_q [3];
	logic signed [COORD_W-1:0] op_a_q [3];
	logic signed [COORD_W-1:0] op_b_q [3];
	logic [CNT_W-1:0]          cnt_q;
	logic                      ovf_q;
	logic signed [SUM_W-1:0]   sum_q [3];
	logic signed [PROD_W-1:0]  prod_q;
	logic [1:0]                part_q;
	logic [SUM_W-1:0]          mag_q;
	logic [SQ_W-1:0]           sq_q;
	logic [REM_W-1:0]          rem_q;
	logic [ROOT_W-1:0]         root_q;
	logic                      out_valid_q;
	logic [AREA_W-1:0]         area_q;
	logic                      out_ovf_q;

	logic                      full;
	logic signed [COORD_W:0]   dif, smm;
	logic signed [MUL_W-1:0]   ma, mb;
	logic signed [SUM_W-1:0]   sel_sum;
	logic [SQ_W-1:0]           term;
	logic [REM_W-1:0]          rem_sh, trial;
	logic [ROOT_W-2:0]         half;
	logic [AREA_W-1:0]         area_root;
	logic [AREA_W-1:0]         res_area;

	assign in_v[0] = x_coord;
	assign in_v[1] = y_coord;
	assign in_v[2] = z_coord;

	assign full         = (cnt_q >= CNT_W'(MAX_VERTS));
	assign sts.has_prev = (cnt_q != '0) && !full;
	assign sts.in_last  = last_vertex;
	assign sts.ovf      = ovf_q;
	assign sts.few      = (cnt_q < CNT_W'(3));
	assign sts.out_free = !out_valid_q || out_ready;

	// edge term operands, a = earlier vertex, b = later vertex
	always_comb begin
		case (cmd.axis)
			AXIS_X: begin
				dif = {op_a_q[1][COORD_W-1], op_a_q[1]} - {op_b_q[1][COORD_W-1], op_b_q[1]};
				smm = {op_a_q[2][COORD_W-1], op_a_q[2]} + {op_b_q[2][COORD_W-1], op_b_q[2]};
			end
			AXIS_Y: begin
				dif = {op_a_q[2][COORD_W-1], op_a_q[2]} - {op_b_q[2][COORD_W-1], op_b_q[2]};
				smm = {op_a_q[0][COORD_W-1], op_a_q[0]} + {op_b_q[0][COORD_W-1], op_b_q[0]};
			end
			default: begin
				dif = {op_a_q[0][COORD_W-1], op_a_q[0]} - {op_b_q[0][COORD_W-1], op_b_q[0]};
				smm = {op_a_q[1][COORD_W-1], op_a_q[1]} + {op_b_q[1][COORD_W-1], op_b_q[1]};
			end
		endcase
	end

	// one shared multiplier for edge terms and square partial products
	always_comb begin
		if (cmd.sq_mul) begin
			ma = {1'b0, (cmd.part == PART_LL) ? mag_q[HALF_W-1:0] : mag_q[SUM_W-1:HALF_W]};
			mb = {1'b0, (cmd.part == PART_HH) ? mag_q[SUM_W-1:HALF_W] : mag_q[HALF_W-1:0]};
		end else begin
			ma = {{(MUL_W-COORD_W-1){dif[COORD_W]}}, dif};
			mb = {{(MUL_W-COORD_W-1){smm[COORD_W]}}, smm};
		end
	end

	always_comb begin
		case (cmd.axis)
			AXIS_X:  sel_sum = sum_q[0];
			AXIS_Y:  sel_sum = sum_q[1];
			default: sel_sum = sum_q[2];
		endcase
	end

	always_comb begin
		case (part_q)
			PART_LL: term = {{(SQ_W-SUM_W){1'b0}}, prod_q[SUM_W-1:0]};
			PART_HL: term = {{(SQ_W-SUM_W){1'b0}}, prod_q[SUM_W-1:0]} << (HALF_W + 1);
			default: term = {{(SQ_W-SUM_W){1'b0}}, prod_q[SUM_W-1:0]} << (2 * HALF_W);
		endcase
	end

	// one restoring square root step: two radicand bits in, one root bit out
	assign rem_sh = {rem_q[REM_W-3:0], sq_q[SQ_W-1:SQ_W-2]};
	assign trial  = rem_sh - {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};

	assign half      = root_q[ROOT_W-1:1];
	assign area_root = (half[ROOT_W-2:AREA_W] != '0) ? {AREA_W{1'b1}} : half[AREA_W-1:0];

	always_comb begin
		case (cmd.res_sel)
			RES_SAT:  res_area = {AREA_W{1'b1}};
			RES_ROOT: res_area = area_root;
			default:  res_area = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			if (cmd.take) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			for (int i = 0; i < 3; i++) begin
				if (cmd.edge_acc && cmd.axis_acc == 2'(i)) begin
					sum_q[i] <= sum_q[i] + {{(SUM_W-34){prod_q[33]}}, prod_q[33:0]};
				end
			end
			if (cmd.load_res) begin
				cnt_q       <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
				for (int i = 0; i < 3; i++) begin
					sum_q[i] <= '0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && !full) begin
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= in_v[i];
				if (cnt_q == '0) begin
					first_q[i] <= in_v[i];
				end else begin
					op_a_q[i] <= prev_q[i];
					op_b_q[i] <= in_v[i];
				end
			end
		end
		if (cmd.close) begin
			for (int i = 0; i < 3; i++) begin
				op_a_q[i] <= prev_q[i];
				op_b_q[i] <= first_q[i];
			end
		end
		if (cmd.edge_mul || cmd.sq_mul) begin
			prod_q <= ma * mb;
			part_q <= cmd.part;
		end
		if (cmd.sq_mag) begin
			mag_q <= sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
		end
		if (cmd.sq_clr) begin
			sq_q   <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sq_acc) begin
			sq_q <= sq_q + term;
		end else if (cmd.root_step) begin
			sq_q <= {sq_q[SQ_W-3:0], 2'b00};
			if (rem_sh >= {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01}) begin
				rem_q  <= trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.load_res) begin
			area_q    <= res_area;
			out_ovf_q <= (cmd.res_sel == RES_SAT);
		end
	end

	assign out_valid       = out_valid_q;
	assign area            = area_q;
	assign vertex_overflow = out_ovf_q;
endmodule
